[src/fwodo_pkg.sv]
// Shared types, constants and helper functions of the four-wheel odometry core.
// Used by fwodo_divider, fwodo_cordic and four_wheel_odometry_core; depends on nothing.
package fwodo_pkg;

   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   localparam int FRACTION_BITS = 16;
   localparam logic [30:0] TRACK_RESET = 31'(10 << FRACTION_BITS);
   localparam int ANGLE_FRAC = 28;
   localparam int DIV_BITS = 64;
   localparam logic [31:0] RAD_TO_BAM = 32'd2734261102;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic [31:0] OCTANT_OFFSET = 32'h2000_0000;
   localparam wide_type SMALL_HALF = 64'sd33554432;
   localparam wide_type Q30_ONE = 64'sd1073741824;
   localparam logic [63:0] ROUND_HALF = 64'd536870912;
   // Reciprocal of six scaled by 2^25; exact floor division for operands below 2^22.
   localparam logic [31:0] SIXTH_RECIPROCAL = 32'd5592406;

   localparam logic CSR_SIDE_TRACK_WIDTH = 1'b0;
   localparam logic CSR_FORE_AFT_TRACK_WIDTH = 1'b1;

   function automatic logic [63:0] mag64(input wide_type v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return (v < 0) ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

[src/four_wheel_odometry_core.sv]
// Four tracking-wheel odometry core: chord-arc pose update with a shared multiplier,
// a serial divider and a CORDIC unit. Depends on fwodo_pkg, fwodo_divider, fwodo_cordic.
//
//   channel   direction  handshake             beat contents
//   req       in         req_valid/req_stall   four wheel positions, time_ms
//   rsp       out        rsp_valid/rsp_stall   x_position, y_position, heading_angle
//   csr       in         csr_write_enable      csr_index, csr_write_data
//
// An item with a new timestamp runs two divisions, a CORDIC pass and a chain of
// multiplications when the heading does not change; a heading change adds a second CORDIC
// pass, and a larger change takes a third division in place of two multiplications.
// An item with a repeated timestamp is taken and gives no beat.
// Reset is synchronous and restores the pose, the stored wheel positions and the widths.
// A new item may be taken while a result beat waits; its own result then holds off
// until the waiting beat is taken.
module four_wheel_odometry_core #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_left_wheel_position,
   input  logic signed [31:0] req_right_wheel_position,
   input  logic signed [31:0] req_back_wheel_position,
   input  logic signed [31:0] req_front_wheel_position,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_x_position,
   output logic signed [47:0] rsp_y_position,
   output logic [31:0]        rsp_heading_angle,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [30:0]        csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_WAIT, ST_DIV1, ST_DIV2, ST_SUMV, ST_BAM, ST_G, ST_G_SQ, ST_GQ,
      ST_SW1, ST_SW2, ST_A, ST_B, ST_CS, ST_P1, ST_P2, ST_P3, ST_P4
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic signed [31:0] prev_pos_ff [4];
   logic signed [31:0] prev_pos_in [4];
   logic [31:0]        prev_time_ff, prev_time_in;
   logic [30:0]        side_w_ff, side_w_in, fa_w_ff, fa_w_in;
   logic [47:0]        pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [31:0]        heading_ff, heading_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               straight_ff, straight_in;
   logic               g_small_ff, g_small_in;

   logic signed [32:0] d_ff [4];
   logic signed [32:0] d_in [4];
   fwodo_pkg::wide_type v1_ff, v1_in, v_ff, v_in, g_ff, g_in;
   fwodo_pkg::wide_type swrl_ff, swrl_in, swfb_ff, swfb_in;
   fwodo_pkg::wide_type u_ff, u_in, w_ff, w_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]        half_ff, half_in, full_ff, full_in;
   logic signed [31:0] sh_ff, sh_in, c_ff, c_in, s_ff, s_in;

   logic               mul_go_ff, mul_go_in, mul_neg_ff, mul_neg_in;
   logic [63:0]        mul_a_ff, mul_a_in;
   logic [31:0]        mul_b_ff, mul_b_in;
   logic               div_go_ff, div_go_in, div_neg_ff, div_neg_in;
   logic [63:0]        div_n_ff, div_n_in, div_d_ff, div_d_in;
   logic               cor_go_ff, cor_go_in;
   logic [31:0]        cor_ang_ff, cor_ang_in;

   logic [1:0]         mul_phase_ff;
   logic [63:0]        mul_acc_ff;
   logic               mul_done_ff;
   logic [63:0]        mul_prod;

   fwodo_pkg::unit_status_type div_status, cor_status;
   logic [63:0]        div_q;
   logic signed [31:0] cor_cos, cor_sin;

   logic               req_accept, op_done, fin_fire;
   logic [30:0]        side_eff, fa_eff;
   fwodo_pkg::wide_type num_side, num_fa, v_sum, div_signed, mq_res, mq_round;
   fwodo_pkg::wide_type d_pick_side, d_pick_fa, mid_side, mid_fa;
   logic [63:0]        mq_rnd_u, g_mag;
   logic [31:0]        half_raw, full_raw;
   logic               pick_left, pick_back;

   fwodo_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .quotient (div_q),
      .status   (div_status)
   );

   fwodo_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_go_ff),
      .angle   (cor_ang_ff),
      .cos_val (cor_cos),
      .sin_val (cor_sin),
      .status  (cor_status)
   );

   // Shared 32x32 multiplier: the wide operand is taken in two halves.
   assign mul_prod = 64'(mul_phase_ff == 2'd1 ? mul_a_ff[31:0] : mul_a_ff[63:32])
                     * 64'(mul_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_phase_ff <= 2'd0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= (mul_phase_ff == 2'd2);
         if (mul_go_ff) begin
            mul_phase_ff <= 2'd1;
         end else if (mul_phase_ff == 2'd1) begin
            mul_phase_ff <= 2'd2;
         end else begin
            mul_phase_ff <= 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_phase_ff == 2'd1) begin
         mul_acc_ff <= mul_prod;
      end else if (mul_phase_ff == 2'd2) begin
         mul_acc_ff <= mul_acc_ff + {mul_prod[31:0], 32'd0};
      end
   end

   always_comb begin
      req_accept = req_valid && !req_stall;
      op_done = mul_done_ff || div_status.done || cor_status.done;
      side_eff = (side_w_ff == '0) ? 31'd1 : side_w_ff;
      fa_eff = (fa_w_ff == '0) ? 31'd1 : fa_w_ff;
      num_side = 64'(d_ff[1]) - 64'(d_ff[0]);
      num_fa = 64'(d_ff[3]) - 64'(d_ff[2]);
      div_signed = div_neg_ff ? -$signed(div_q) : $signed(div_q);
      v_sum = v1_ff + div_signed;
      mq_rnd_u = mul_acc_ff + fwodo_pkg::ROUND_HALF;
      mq_round = $signed({30'd0, mq_rnd_u[63:30]});
      mq_res = mul_neg_ff ? -mq_round : mq_round;
      half_raw = mul_acc_ff[62:31];
      full_raw = mul_acc_ff[61:30];
      g_mag = fwodo_pkg::mag64(g_ff);
      pick_left = fwodo_pkg::mag64(64'(d_ff[0])) > fwodo_pkg::mag64(64'(d_ff[1]));
      pick_back = fwodo_pkg::mag64(64'(d_ff[2])) > fwodo_pkg::mag64(64'(d_ff[3]));
      d_pick_side = pick_left ? 64'(d_ff[0]) : 64'(d_ff[1]);
      d_pick_fa = pick_back ? 64'(d_ff[2]) : 64'(d_ff[3]);
      mid_side = (64'(d_ff[0]) + 64'(d_ff[1])) >>> 1;
      mid_fa = (64'(d_ff[2]) + 64'(d_ff[3])) >>> 1;
      fin_fire = (state_ff == ST_P4) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      prev_pos_in = prev_pos_ff;
      prev_time_in = prev_time_ff;
      side_w_in = side_w_ff;
      fa_w_in = fa_w_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      heading_in = heading_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      straight_in = straight_ff;
      g_small_in = g_small_ff;
      d_in = d_ff;
      v1_in = v1_ff;
      v_in = v_ff;
      g_in = g_ff;
      swrl_in = swrl_ff;
      swfb_in = swfb_ff;
      u_in = u_ff;
      w_in = w_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      half_in = half_ff;
      full_in = full_ff;
      sh_in = sh_ff;
      c_in = c_ff;
      s_in = s_ff;
      mul_go_in = 1'b0;
      mul_neg_in = mul_neg_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      div_go_in = 1'b0;
      div_neg_in = div_neg_ff;
      div_n_in = div_n_ff;
      div_d_in = div_d_ff;
      cor_go_in = 1'b0;
      cor_ang_in = cor_ang_ff;

      if (csr_write_enable) begin
         case (csr_index)
            fwodo_pkg::CSR_SIDE_TRACK_WIDTH: side_w_in = csr_write_data;
            fwodo_pkg::CSR_FORE_AFT_TRACK_WIDTH: fa_w_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_time_ms != prev_time_ff) begin
               d_in[0] = 33'(req_left_wheel_position) - 33'(prev_pos_ff[0]);
               d_in[1] = 33'(req_right_wheel_position) - 33'(prev_pos_ff[1]);
               d_in[2] = 33'(req_back_wheel_position) - 33'(prev_pos_ff[2]);
               d_in[3] = 33'(req_front_wheel_position) - 33'(prev_pos_ff[3]);
               prev_pos_in[0] = req_left_wheel_position;
               prev_pos_in[1] = req_right_wheel_position;
               prev_pos_in[2] = req_back_wheel_position;
               prev_pos_in[3] = req_front_wheel_position;
               prev_time_in = req_time_ms;
               state_in = ST_DIV1;
            end
         end
         ST_WAIT: begin
            if (op_done) begin
               state_in = ret_ff;
            end
         end
         ST_DIV1: begin
            div_n_in = fwodo_pkg::mag64(num_side) << fwodo_pkg::ANGLE_FRAC;
            div_d_in = {32'd0, side_eff, 1'b0};
            div_neg_in = num_side < 0;
            div_go_in = 1'b1;
            ret_in = ST_DIV2;
            state_in = ST_WAIT;
         end
         ST_DIV2: begin
            v1_in = div_signed;
            div_n_in = fwodo_pkg::mag64(num_fa) << fwodo_pkg::ANGLE_FRAC;
            div_d_in = {32'd0, fa_eff, 1'b0};
            div_neg_in = num_fa < 0;
            div_go_in = 1'b1;
            ret_in = ST_SUMV;
            state_in = ST_WAIT;
         end
         ST_SUMV: begin
            v_in = v_sum;
            if (v_sum == 0) begin
               straight_in = 1'b1;
               u_in = mid_side;
               w_in = mid_fa;
               cor_ang_in = heading_ff;
               cor_go_in = 1'b1;
               ret_in = ST_CS;
            end else begin
               straight_in = 1'b0;
               mul_a_in = fwodo_pkg::mag64(v_sum);
               mul_b_in = fwodo_pkg::RAD_TO_BAM;
               mul_neg_in = 1'b0;
               mul_go_in = 1'b1;
               ret_in = ST_BAM;
            end
            state_in = ST_WAIT;
         end
         ST_BAM: begin
            half_in = (v_ff < 0) ? 32'd0 - half_raw : half_raw;
            full_in = (v_ff < 0) ? 32'd0 - full_raw : full_raw;
            cor_ang_in = (v_ff < 0) ? 32'd0 - half_raw : half_raw;
            cor_go_in = 1'b1;
            ret_in = ST_G;
            state_in = ST_WAIT;
         end
         ST_G: begin
            sh_in = cor_sin;
            if (v_ff > -fwodo_pkg::SMALL_HALF && v_ff < fwodo_pkg::SMALL_HALF) begin
               g_small_in = 1'b1;
               mul_a_in = fwodo_pkg::mag64(v_ff);
               mul_b_in = mul_a_in[31:0];
               mul_neg_in = 1'b0;
               mul_go_in = 1'b1;
               ret_in = ST_G_SQ;
            end else begin
               g_small_in = 1'b0;
               div_n_in = {3'd0, fwodo_pkg::mag32(cor_sin), 29'd0};
               div_d_in = fwodo_pkg::mag64(v_ff);
               div_neg_in = (cor_sin < 0) != (v_ff < 0);
               div_go_in = 1'b1;
               ret_in = ST_GQ;
            end
            state_in = ST_WAIT;
         end
         ST_G_SQ: begin
            mul_a_in = {28'd0, mul_acc_ff[63:28]};
            mul_b_in = fwodo_pkg::SIXTH_RECIPROCAL;
            mul_neg_in = 1'b0;
            mul_go_in = 1'b1;
            ret_in = ST_GQ;
            state_in = ST_WAIT;
         end
         ST_GQ: begin
            g_in = g_small_ff ? fwodo_pkg::Q30_ONE - $signed({25'd0, mul_acc_ff[63:25]})
                              : div_signed;
            mul_a_in = {33'd0, side_eff};
            mul_b_in = fwodo_pkg::mag32(sh_ff);
            mul_neg_in = sh_ff < 0;
            mul_go_in = 1'b1;
            ret_in = ST_SW1;
            state_in = ST_WAIT;
         end
         ST_SW1: begin
            swrl_in = mq_res;
            mul_a_in = {33'd0, fa_eff};
            mul_b_in = fwodo_pkg::mag32(sh_ff);
            mul_neg_in = sh_ff < 0;
            mul_go_in = 1'b1;
            ret_in = ST_SW2;
            state_in = ST_WAIT;
         end
         ST_SW2: begin
            swfb_in = mq_res;
            mul_a_in = fwodo_pkg::mag64(d_pick_side);
            mul_b_in = g_mag[31:0];
            mul_neg_in = (g_ff < 0) != (d_pick_side < 0);
            mul_go_in = 1'b1;
            ret_in = ST_A;
            state_in = ST_WAIT;
         end
         ST_A: begin
            u_in = pick_left ? mq_res + swrl_ff : mq_res - swrl_ff;
            mul_a_in = fwodo_pkg::mag64(d_pick_fa);
            mul_b_in = g_mag[31:0];
            mul_neg_in = (g_ff < 0) != (d_pick_fa < 0);
            mul_go_in = 1'b1;
            ret_in = ST_B;
            state_in = ST_WAIT;
         end
         ST_B: begin
            w_in = pick_back ? mq_res + swfb_ff : mq_res - swfb_ff;
            cor_ang_in = heading_ff + half_ff;
            cor_go_in = 1'b1;
            ret_in = ST_CS;
            state_in = ST_WAIT;
         end
         ST_CS: begin
            c_in = cor_cos;
            s_in = cor_sin;
            mul_a_in = fwodo_pkg::mag64(u_ff);
            mul_b_in = fwodo_pkg::mag32(cor_cos);
            mul_neg_in = (u_ff < 0) != (cor_cos < 0);
            mul_go_in = 1'b1;
            ret_in = ST_P1;
            state_in = ST_WAIT;
         end
         ST_P1: begin
            dx_in = mq_res;
            mul_a_in = fwodo_pkg::mag64(w_ff);
            mul_b_in = fwodo_pkg::mag32(s_ff);
            mul_neg_in = (w_ff < 0) != (s_ff < 0);
            mul_go_in = 1'b1;
            ret_in = ST_P2;
            state_in = ST_WAIT;
         end
         ST_P2: begin
            dx_in = dx_ff - mq_res;
            mul_a_in = fwodo_pkg::mag64(w_ff);
            mul_b_in = fwodo_pkg::mag32(c_ff);
            mul_neg_in = (w_ff < 0) != (c_ff < 0);
            mul_go_in = 1'b1;
            ret_in = ST_P3;
            state_in = ST_WAIT;
         end
         ST_P3: begin
            dy_in = mq_res;
            mul_a_in = fwodo_pkg::mag64(u_ff);
            mul_b_in = fwodo_pkg::mag32(s_ff);
            mul_neg_in = (u_ff < 0) != (s_ff < 0);
            mul_go_in = 1'b1;
            ret_in = ST_P4;
            state_in = ST_WAIT;
         end
         ST_P4: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               pose_x_in = pose_x_ff + dx_ff[47:0];
               dy_in = dy_ff + mq_res;
               pose_y_in = pose_y_ff + dy_in[47:0];
               if (!straight_ff) begin
                  heading_in = heading_ff + full_ff;
               end
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         for (int i = 0; i < 4; i++) begin
            prev_pos_ff[i] <= '0;
         end
         prev_time_ff <= '0;
         side_w_ff <= fwodo_pkg::TRACK_RESET;
         fa_w_ff <= fwodo_pkg::TRACK_RESET;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         heading_ff <= '0;
         rsp_valid_ff <= 1'b0;
         straight_ff <= 1'b0;
         g_small_ff <= 1'b0;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         cor_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         prev_pos_ff <= prev_pos_in;
         prev_time_ff <= prev_time_in;
         side_w_ff <= side_w_in;
         fa_w_ff <= fa_w_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         heading_ff <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
         straight_ff <= straight_in;
         g_small_ff <= g_small_in;
         mul_go_ff <= mul_go_in;
         div_go_ff <= div_go_in;
         cor_go_ff <= cor_go_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      v1_ff <= v1_in;
      v_ff <= v_in;
      g_ff <= g_in;
      swrl_ff <= swrl_in;
      swfb_ff <= swfb_in;
      u_ff <= u_in;
      w_ff <= w_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      half_ff <= half_in;
      full_ff <= full_in;
      sh_ff <= sh_in;
      c_ff <= c_in;
      s_ff <= s_in;
      mul_neg_ff <= mul_neg_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      div_neg_ff <= div_neg_in;
      div_n_ff <= div_n_in;
      div_d_ff <= div_d_in;
      cor_ang_ff <= cor_ang_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_position = $signed(pose_x_ff);
   assign rsp_y_position = $signed(pose_y_ff);
   assign rsp_heading_angle = heading_ff;

   // The sequencer never runs two of its arithmetic units at once.
   a_one_unit_busy: assert property (@(posedge clock) disable iff (reset)
      $onehot0({div_status.busy, cor_status.busy, mul_phase_ff != 2'd0}))
      else $error("more than one arithmetic unit busy");

   // A result beat appears only out of the final accumulation step.
   a_beat_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_P4))
      else $error("result beat raised outside the final step");

   // A straight update never turns the heading.
   a_straight_keeps_heading: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && straight_ff) |=> $stable(heading_ff))
      else $error("heading changed on a straight update");

endmodule

[src/fwodo_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle for all 64 quotient bits.
// Depends on fwodo_pkg for the bit count and the status struct.
module fwodo_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 dividend,
   input  logic [63:0]                 divisor,
   output logic [63:0]                 quotient,
   output fwodo_pkg::unit_status_type  status
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff = shifted - {1'b0, den_ff};
      fits = shifted >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(fwodo_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[src/fwodo_cordic.sv]
// Iterative binary-angle CORDIC giving Q30 cosine and sine, one rotation per cycle.
// Depends on fwodo_pkg for the gain, the arctangent table and the status struct.
module fwodo_cordic #(
   parameter int ITERATIONS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 angle,
   output logic signed [31:0]          cos_val,
   output logic signed [31:0]          sin_val,
   output fwodo_pkg::unit_status_type  status
);

   localparam int CW = $clog2(ITERATIONS);

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [1:0]         q_ff, q_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [31:0]        shifted_angle;
   logic [31:0]        residual;
   logic signed [31:0] xs, ys, xn, yn;
   logic signed [33:0] step;

   always_comb begin
      shifted_angle = angle + fwodo_pkg::OCTANT_OFFSET;
      residual = angle - {shifted_angle[31:30], 30'd0};
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      step = $signed({2'b00, fwodo_pkg::atan_bam(5'(cnt_ff))});
      if (z_ff >= 0) begin
         xn = x_ff - ys;
         yn = y_ff + xs;
         z_in = z_ff - step;
      end else begin
         xn = x_ff + ys;
         yn = y_ff - xs;
         z_in = z_ff + step;
      end
      x_in = x_ff;
      y_in = y_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cos_in = cos_ff;
      sin_in = sin_ff;
      if (start) begin
         x_in = fwodo_pkg::CORDIC_GAIN;
         y_in = '0;
         z_in = 34'($signed(residual));
         q_in = shifted_angle[31:30];
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = xn;
         y_in = yn;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            case (q_ff)
               2'd0: begin
                  cos_in = xn;
                  sin_in = yn;
               end
               2'd1: begin
                  cos_in = -yn;
                  sin_in = xn;
               end
               2'd2: begin
                  cos_in = -xn;
                  sin_in = -yn;
               end
               default: begin
                  cos_in = yn;
                  sin_in = -xn;
               end
            endcase
         end
      end else begin
         z_in = z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      q_ff <= q_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench of four_wheel_odometry_core: directed rows, then random samples.
// It predicts each pose beat with its own arc-odometry model, or takes it from a row that
// carries its own expected pose, and compares field by field. Depends on fwodo_pkg and four_wheel_odometry_core.
`timescale 1ns / 100ps

module tb_top;

   localparam int STEPS = 24;
   localparam int PHASE_RESULTS = 190;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [31:0] ATAN_STEP [0:31] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1, 0};

   typedef struct {
      logic signed [31:0] pos [4];
      logic [31:0]        stamp;
      bit                 typed;
      logic signed [47:0] ex;
      logic signed [47:0] ey;
      logic [31:0]        eh;
   } sample_type;

   typedef struct {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic [31:0]        h;
   } pose_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_left_wheel_position = '0;
   logic signed [31:0] req_right_wheel_position = '0;
   logic signed [31:0] req_back_wheel_position = '0;
   logic signed [31:0] req_front_wheel_position = '0;
   logic [31:0]        req_time_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [47:0] rsp_x_position;
   logic signed [47:0] rsp_y_position;
   logic [31:0]        rsp_heading_angle;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = fwodo_pkg::CSR_SIDE_TRACK_WIDTH;
   logic [30:0]        csr_write_data = '0;

   // Predictor state.
   logic [30:0] side_width;
   logic [30:0] fore_aft_width;
   longint      last_pos [4];
   logic [31:0] last_stamp;
   logic [47:0] pose_x;
   logic [47:0] pose_y;
   logic [31:0] pose_heading;

   pose_type pending_poses [$];
   int     mismatches = 0;
   int     beats_checked = 0;
   int     skipped_samples = 0;
   int     predicted_beats = 0;
   int     settings_used = 0;
   longint cycles = 0;
   bit     quiet = 1'b0;
   int     hold_requests = 0;
   int     holds_served = 0;
   sample_type rows [$];

   four_wheel_odometry_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint round_q30(input longint a, input longint b);
      logic [63:0] r;
      r = (magnitude(a) * magnitude(b) + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [31:0] radians_to_angle(input longint v, input int sh);
      logic [63:0] m, lo, hi, r;
      m = magnitude(v);
      lo = {32'b0, m[31:0]} * {32'b0, fwodo_pkg::RAD_TO_BAM};
      hi = (m >> 32) * {32'b0, fwodo_pkg::RAD_TO_BAM};
      r = (hi << (32 - sh)) + (lo >> sh);
      if (v < 0) r = -r;
      return r[31:0];
   endfunction

   task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic [63:0] t;
      logic [1:0]  q;
      logic [31:0] zr;
      longint      z, x, y, xs, ys;
      t = {32'b0, ang} + 64'h2000_0000;
      q = t[31:30];
      zr = ang - {q, 30'b0};
      z = longint'($signed(zr));
      x = longint'(fwodo_pkg::CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_STEP[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_STEP[i]);
         end
      end
      case (q)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   // Advances the tracked pose by one sample; returns 0 for a repeated timestamp.
   task automatic advance_pose(input sample_type smp, output bit produced, output pose_type p);
      longint d [4];
      longint wrl, wfb, v, dv, dsv, c, s, ch, sh, g, a, b, swrl, swfb, dx, dy;
      logic [31:0] half, full;
      produced = 1'b0;
      p = '{default: '0};
      if (smp.stamp == last_stamp) return;
      for (int i = 0; i < 4; i++) begin
         d[i] = longint'(smp.pos[i]) - last_pos[i];
         last_pos[i] = longint'(smp.pos[i]);
      end
      last_stamp = smp.stamp;
      wrl = (side_width == 0) ? 1 : longint'(side_width);
      wfb = (fore_aft_width == 0) ? 1 : longint'(fore_aft_width);
      v = ((d[1] - d[0]) * (64'sd1 <<< 28)) / (2 * wrl)
        + ((d[3] - d[2]) * (64'sd1 <<< 28)) / (2 * wfb);
      if (v == 0) begin
         dv = (d[0] + d[1]) >>> 1;
         dsv = (d[2] + d[3]) >>> 1;
         sin_cos(pose_heading, c, s);
         dx = round_q30(c, dv) - round_q30(s, dsv);
         dy = round_q30(c, dsv) + round_q30(s, dv);
      end else begin
         half = radians_to_angle(v, 31);
         full = radians_to_angle(v, 30);
         sin_cos(half, ch, sh);
         if (v > -fwodo_pkg::SMALL_HALF && v < fwodo_pkg::SMALL_HALF)
            g = fwodo_pkg::Q30_ONE - longint'((64'(v * v) >> 28) / 64'd6);
         else
            g = (sh * (64'sd1 <<< 29)) / v;
         swrl = round_q30(sh, wrl);
         swfb = round_q30(sh, wfb);
         a = (magnitude(d[0]) > magnitude(d[1])) ? round_q30(g, d[0]) + swrl
                                                 : round_q30(g, d[1]) - swrl;
         b = (magnitude(d[2]) > magnitude(d[3])) ? round_q30(g, d[2]) + swfb
                                                 : round_q30(g, d[3]) - swfb;
         sin_cos(pose_heading + half, c, s);
         dx = round_q30(c, a) - round_q30(s, b);
         dy = round_q30(c, b) + round_q30(s, a);
         pose_heading = pose_heading + full;
      end
      pose_x = pose_x + dx[47:0];
      pose_y = pose_y + dy[47:0];
      produced = 1'b1;
      p.x = pose_x;
      p.y = pose_y;
      p.h = pose_heading;
   endtask

   task automatic write_width(input logic idx, input logic [30:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == fwodo_pkg::CSR_SIDE_TRACK_WIDTH) side_width = value;
      else fore_aft_width = value;
   endtask

   task automatic send_sample(input sample_type smp);
      bit       produced;
      pose_type p;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_wheel_position <= smp.pos[0];
      req_right_wheel_position <= smp.pos[1];
      req_back_wheel_position <= smp.pos[2];
      req_front_wheel_position <= smp.pos[3];
      req_time_ms <= smp.stamp;
      do @(posedge clock); while (req_stall);
      advance_pose(smp, produced, p);
      if (produced) begin
         predicted_beats++;
         if (smp.typed) begin
            p.x = smp.ex; p.y = smp.ey; p.h = smp.eh;
         end
         pending_poses.push_back(p);
      end else begin
         skipped_samples++;
      end
      @(negedge clock);
   endtask

   function automatic longint random_delta();
      longint m;
      m = longint'($urandom_range(0, (1 << $urandom_range(0, 22)) - 1));
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic sample_type next_sample();
      sample_type smp;
      int      kind;
      longint  k, j;
      smp = '{default: '0};
      kind = $urandom_range(0, 99);
      smp.stamp = last_stamp + $urandom_range(1, 40);
      k = random_delta();
      j = random_delta();
      if (kind < 8) begin
         smp.stamp = last_stamp;
         for (int i = 0; i < 4; i++) smp.pos[i] = $urandom;
      end else if (kind < 14) begin
         smp.stamp = $urandom;
         for (int i = 0; i < 4; i++) smp.pos[i] = $urandom;
      end else if (kind < 30) begin
         smp.pos[0] = 32'(last_pos[0] + k);
         smp.pos[1] = 32'(last_pos[1] + k);
         smp.pos[2] = 32'(last_pos[2] + j);
         smp.pos[3] = 32'(last_pos[3] + j);
      end else if (kind < 45) begin
         smp.pos[0] = 32'(last_pos[0] + k);
         smp.pos[1] = 32'(last_pos[1] + k + $urandom_range(0, 8) - 4);
         smp.pos[2] = 32'(last_pos[2] + j);
         smp.pos[3] = 32'(last_pos[3] + j + $urandom_range(0, 8) - 4);
      end else begin
         for (int i = 0; i < 4; i++) smp.pos[i] = 32'(last_pos[i] + random_delta());
      end
      return smp;
   endfunction

   function automatic sample_type make_row(input logic [31:0] l, r, b, f,
                                           input logic [31:0] stamp);
      sample_type smp;
      smp = '{default: '0};
      smp.pos[0] = l; smp.pos[1] = r; smp.pos[2] = b; smp.pos[3] = f;
      smp.stamp = stamp;
      return smp;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (400) @(negedge clock);
   endtask

   // Receiver side: random stall bursts and, on request, one long hold-off.
   int burst = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst > 0) begin
         burst--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         burst = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      pose_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_poses.size() == 0) begin
            $error("pose beat with no sample pending");
            mismatches++;
         end else begin
            e = pending_poses.pop_front();
            beats_checked++;
            if (rsp_x_position !== e.x) begin
               $error("x_position expected %0h got %0h", e.x, rsp_x_position);
               mismatches++;
            end
            if (rsp_y_position !== e.y) begin
               $error("y_position expected %0h got %0h", e.y, rsp_y_position);
               mismatches++;
            end
            if (rsp_heading_angle !== e.h) begin
               $error("heading_angle expected %0h got %0h", e.h, rsp_heading_angle);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [30:0] side_set [5];
      logic [30:0] fore_set [5];
      sample_type  smp;
      int          goal;
      side_width = fwodo_pkg::TRACK_RESET;
      fore_aft_width = fwodo_pkg::TRACK_RESET;
      for (int i = 0; i < 4; i++) last_pos[i] = 0;
      last_stamp = '0;
      pose_x = '0; pose_y = '0; pose_heading = '0;
      side_set = '{fwodo_pkg::TRACK_RESET, 31'd1, 31'h7FFF_FFFF, 31'd0,
                   31'($urandom_range(1, 1 << 24))};
      fore_set = '{fwodo_pkg::TRACK_RESET, 31'h7FFF_FFFF, 31'd1, 31'd0,
                   31'($urandom_range(1, 1 << 24))};

      rows.push_back(make_row(0, 0, 0, 0, 0));
      smp = make_row(0, 0, 0, 0, 1);
      smp.typed = 1'b1;
      rows.push_back(smp);
      rows.push_back(make_row(32'h1234, 32'h9999, 32'h5, 32'h77, 1));
      rows.push_back(make_row(32'h10000, 32'h10000, 32'h10000, 32'h10000, 2));
      rows.push_back(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3));
      rows.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4));
      rows.push_back(make_row(32'h8010_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5));
      rows.push_back(make_row(32'h8010_0000, 32'h8030_0000, 32'h8000_0000, 32'h8000_0000, 6));
      rows.push_back(make_row(32'h8010_0000, 32'h8030_0000, 32'h8005_0000, 32'h8000_0000, 7));
      rows.push_back(make_row(32'h8010_0000, 32'h8030_0000, 32'h8005_0000, 32'h8009_0000, 8));
      rows.push_back(make_row(32'h8011_0000, 32'h802F_0000, 32'h8004_0000, 32'h800A_0000, 9));
      rows.push_back(make_row(32'h8011_0001, 32'h802F_0002, 32'h8004_0000, 32'h800A_0000, 10));
      rows.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 11));
      rows.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 12));
      rows.push_back(make_row(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
      rows.push_back(make_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 0));
      rows.push_back(make_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 0));
      rows.push_back(make_row(32'h5556_5555, 32'hAAAB_AAAA, 32'h3334_3333, 32'hCCCD_CCCC, 7));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_sample(rows[i]);
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         write_width(fwodo_pkg::CSR_SIDE_TRACK_WIDTH, side_set[ph]);
         write_width(fwodo_pkg::CSR_FORE_AFT_TRACK_WIDTH, fore_set[ph]);
         settings_used++;
         quiet = (ph == 4);
         goal = predicted_beats + PHASE_RESULTS;
         while (predicted_beats < goal) begin
            if (ph == 1 && predicted_beats == goal - 150) hold_requests++;
            send_sample(next_sample());
         end
         wait_drained();
      end

      $display("Checked %0d pose beats over %0d track settings; %0d repeated-timestamp samples.",
               beats_checked, settings_used, skipped_samples);
      if (mismatches == 0 && pending_poses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
src/fwodo_pkg.sv
src/fwodo_divider.sv
src/fwodo_cordic.sv
src/four_wheel_odometry_core.sv
verif/tb_top.sv
